// File: rtl/core/quadrature_position_speed_defines.svh
// Assertion macros shared by the quadrature position and speed block.
`ifndef QUADRATURE_POSITION_SPEED_DEFINES_SVH
`define QUADRATURE_POSITION_SPEED_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define QPS_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define QPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define QPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define QPS_ASSERT_HOLDS(label, clk, rst, expr, msg)
`define QPS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define QPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/qps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qps_pkg;

   localparam int DATA_W     = 32;
   localparam int PERIOD_W   = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_PHASE_A_MASK = 2'd0;
   localparam csr_idx_type REG_PHASE_B_MASK = 2'd1;
   localparam csr_idx_type REG_PERIOD_MS    = 2'd2;
   localparam csr_idx_type REG_SPEED_SCALE  = 2'd3;

   localparam logic [DATA_W-1:0]   PHASE_A_MASK_RESET = 32'd1;
   localparam logic [DATA_W-1:0]   PHASE_B_MASK_RESET = 32'd2;
   localparam logic [PERIOD_W-1:0] PERIOD_MS_RESET    = 16'd10;
   localparam logic [PERIOD_W-1:0] SPEED_SCALE_RESET  = 16'd100;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TIME   = 1'b1;

   // bit n set: transition code n steps the position
   localparam logic [15:0] STEP_UP_CODES   = 16'h2814;
   localparam logic [15:0] STEP_DOWN_CODES = 16'h4182;

   typedef struct packed {
      logic              command;
      logic [DATA_W-1:0] port_bits;
      logic [DATA_W-1:0] now_ms;
   } qps_item_type;

endpackage

`default_nettype wire

// File: rtl/core/qps_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qps_req_if import qps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [DATA_W-1:0] port_bits;
   logic [DATA_W-1:0] now_ms;

   modport source (output valid, command, port_bits, now_ms, input ready);
   modport sink   (input valid, command, port_bits, now_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/core/qps_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qps_rsp_if import qps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] position;
   logic signed [DATA_W-1:0] speed;

   modport source (output valid, position, speed, input ready);
   modport sink   (input valid, position, speed, output ready);
endinterface

`default_nettype wire

// File: rtl/core/quadrature_position_speed.sv
// Quadrature encoder 4x decoder with periodic position and speed report.
// req_item carries one item per handshake: command 0 is a port sample, whose
// masked phase bits step the 32-bit position up or down; command 1 is a time
// update with the current millisecond count. A time update that has reached
// the due time yields one rsp_item item with the position and the position
// change since the last report times speed_scale. Other items yield nothing.
// One item is taken every cycle unless a due time update waits. An item
// passes the input register, a decode, state update and multiply step,
// and the result register, where a report waits until rsp_item takes it.
// When rsp_item stalls, the result register holds; a due time update then
// waits in the input register and blocks req_item until the result leaves.
// Port samples and time updates that are not due never wait.
// Reset (synchronous) clears position, phase, last report and due time to
// zero, empties both registers and loads the register defaults. csr_* is an
// APB write/read port: phase A mask, phase B mask, period, scale at byte
// addresses 0, 4, 8, 12; pready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_position_speed_defines.svh"

module quadrature_position_speed import qps_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   qps_req_if.sink                    req_item,
   qps_rsp_if.source                  rsp_item,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0]     csr_pwdata,
   output logic      [DATA_W-1:0]     csr_prdata,
   output logic                       csr_pready
);

   logic [DATA_W-1:0]   phase_a_mask_ff, phase_a_mask_in;
   logic [DATA_W-1:0]   phase_b_mask_ff, phase_b_mask_in;
   logic [PERIOD_W-1:0] period_ms_ff, period_ms_in;
   logic [PERIOD_W-1:0] speed_scale_ff, speed_scale_in;

   logic                csr_write;
   csr_idx_type         csr_idx;

   logic                v0_ff, v0_in;
   qps_item_type        item0_ff, item0_in;
   logic [1:0]          last_phases_ff, last_phases_in;
   logic [DATA_W-1:0]   position_ff, position_in;
   logic [DATA_W-1:0]   last_sampled_ff, last_sampled_in;
   logic [DATA_W-1:0]   next_due_ff, next_due_in;

   logic                vout_ff, vout_in;
   logic [DATA_W-1:0]   pos_out_ff, pos_out_in;
   logic [DATA_W-1:0]   speed_out_ff, speed_out_in;

   logic [1:0]          phase_now;
   logic [3:0]          code;
   logic [DATA_W-1:0]   delta;
   logic                step_up, step_down, due, emit, s0_consume, emit_go;
   logic                out_free;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      phase_a_mask_in = phase_a_mask_ff;
      phase_b_mask_in = phase_b_mask_ff;
      period_ms_in    = period_ms_ff;
      speed_scale_in  = speed_scale_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_PHASE_A_MASK: phase_a_mask_in = csr_pwdata;
            REG_PHASE_B_MASK: phase_b_mask_in = csr_pwdata;
            REG_PERIOD_MS:    period_ms_in    = csr_pwdata[PERIOD_W-1:0];
            REG_SPEED_SCALE:  speed_scale_in  = csr_pwdata[PERIOD_W-1:0];
            default:          phase_a_mask_in = phase_a_mask_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PHASE_A_MASK: csr_prdata = phase_a_mask_ff;
         REG_PHASE_B_MASK: csr_prdata = phase_b_mask_ff;
         REG_PERIOD_MS:    csr_prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_ms_ff};
         REG_SPEED_SCALE:  csr_prdata = {{(DATA_W-PERIOD_W){1'b0}}, speed_scale_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign out_free = !vout_ff || rsp_item.ready;

   assign phase_now  = {|(item0_ff.port_bits & phase_a_mask_ff),
                        |(item0_ff.port_bits & phase_b_mask_ff)};
   assign code       = {last_phases_ff, phase_now};
   assign step_up    = STEP_UP_CODES[code];
   assign step_down  = STEP_DOWN_CODES[code];
   assign due        = item0_ff.now_ms >= next_due_ff;
   assign emit       = v0_ff && (item0_ff.command == CMD_TIME) && due;
   assign s0_consume = v0_ff && (!emit || out_free);
   assign emit_go    = emit && out_free;
   assign delta      = position_ff - last_sampled_ff;

   assign req_item.ready = !v0_ff || s0_consume;

   always_comb begin
      v0_in           = v0_ff;
      item0_in        = item0_ff;
      last_phases_in  = last_phases_ff;
      position_in     = position_ff;
      last_sampled_in = last_sampled_ff;
      next_due_in     = next_due_ff;
      if (req_item.ready) begin
         v0_in    = req_item.valid;
         item0_in = '{command: req_item.command, port_bits: req_item.port_bits,
                      now_ms: req_item.now_ms};
      end
      if (s0_consume) begin
         if (item0_ff.command == CMD_SAMPLE) begin
            last_phases_in = phase_now;
            if (step_up) begin
               position_in = position_ff + 32'd1;
            end else if (step_down) begin
               position_in = position_ff - 32'd1;
            end
         end else if (due) begin
            next_due_in     = item0_ff.now_ms + {{(DATA_W-PERIOD_W){1'b0}}, period_ms_ff};
            last_sampled_in = position_ff;
         end
      end
   end

   always_comb begin
      vout_in      = vout_ff;
      pos_out_in   = pos_out_ff;
      speed_out_in = speed_out_ff;
      if (out_free) begin
         vout_in = emit_go;
         if (emit_go) begin
            pos_out_in   = position_ff;
            speed_out_in = delta * {{(DATA_W-PERIOD_W){1'b0}}, speed_scale_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_a_mask_ff <= PHASE_A_MASK_RESET;
         phase_b_mask_ff <= PHASE_B_MASK_RESET;
         period_ms_ff    <= PERIOD_MS_RESET;
         speed_scale_ff  <= SPEED_SCALE_RESET;
         v0_ff           <= 1'b0;
         last_phases_ff  <= 2'b00;
         position_ff     <= '0;
         last_sampled_ff <= '0;
         next_due_ff     <= '0;
         vout_ff         <= 1'b0;
      end else begin
         phase_a_mask_ff <= phase_a_mask_in;
         phase_b_mask_ff <= phase_b_mask_in;
         period_ms_ff    <= period_ms_in;
         speed_scale_ff  <= speed_scale_in;
         v0_ff           <= v0_in;
         last_phases_ff  <= last_phases_in;
         position_ff     <= position_in;
         last_sampled_ff <= last_sampled_in;
         next_due_ff     <= next_due_in;
         vout_ff         <= vout_in;
      end
   end

   always_ff @(posedge clock) begin
      item0_ff     <= item0_in;
      pos_out_ff   <= pos_out_in;
      speed_out_ff <= speed_out_in;
   end

   assign rsp_item.valid    = vout_ff;
   assign rsp_item.position = $signed(pos_out_ff);
   assign rsp_item.speed    = $signed(speed_out_ff);

   `QPS_ASSERT_HOLDS(a_sample_never_waits, clock, reset, !(v0_ff && (item0_ff.command == CMD_SAMPLE)) || s0_consume, "port sample item stalled in decode stage")
   `QPS_ASSERT_NEXT(a_position_single_step, clock, reset, s0_consume && (item0_ff.command == CMD_SAMPLE), (position_ff - $past(position_ff)) == 32'd0 || (position_ff - $past(position_ff)) == 32'd1 || (position_ff - $past(position_ff)) == 32'hFFFF_FFFF, "position moved by more than one count")
   `QPS_ASSERT_NEXT(a_not_due_keeps_deadline, clock, reset, v0_ff && (item0_ff.command == CMD_TIME) && !due, $stable(next_due_ff) && $stable(last_sampled_ff), "time update that is not due changed report state")
   `QPS_ASSERT_SAME(a_result_from_due_update, clock, reset, $rose(vout_ff), $past(emit_go), "result appeared without a due time update")

endmodule

`default_nettype wire

// File: tb/quadrature_position_speed_tb.sv
`timescale 1ns / 1ps

module quadrature_position_speed_tb;
   import qps_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_COUNT    = 8;
   localparam int ITEMS_PER_PHASE = 250;

   typedef struct {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] speed;
   } report_type;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   qps_req_if req_bus ();
   qps_rsp_if rsp_bus ();

   quadrature_position_speed uut (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_bus),
      .rsp_item    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // register copies
   logic [DATA_W-1:0]   a_mask = PHASE_A_MASK_RESET;
   logic [DATA_W-1:0]   b_mask = PHASE_B_MASK_RESET;
   logic [PERIOD_W-1:0] period = PERIOD_MS_RESET;
   logic [PERIOD_W-1:0] scale  = SPEED_SCALE_RESET;

   // encoder state as the block should hold it
   logic [1:0]        enc_phase      = 2'b00;
   logic [DATA_W-1:0] enc_count      = '0;
   logic [DATA_W-1:0] reported_count = '0;
   logic [DATA_W-1:0] due_ms         = '0;

   // stimulus generator state
   logic [1:0]        gen_ab  = 2'b00;
   logic [DATA_W-1:0] gen_now = '0;
   logic [DATA_W-1:0] gen_due = '0;
   logic              walk_up = 1'b1;

   qps_item_type pending_items[$];
   report_type   expected_reports[$];
   qps_item_type drive_item;
   report_type   want;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int items_taken   = 0;
   int reports_seen  = 0;
   int settings_used = 1;
   int cycles        = 0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   task automatic decode_item(qps_item_type it);
      logic [1:0] cur;
      logic [3:0] code;
      report_type r;
      if (it.command == CMD_SAMPLE) begin
         cur  = {|(it.port_bits & a_mask), |(it.port_bits & b_mask)};
         code = {enc_phase, cur};
         if (STEP_UP_CODES[code])
            enc_count = enc_count + 1;
         else if (STEP_DOWN_CODES[code])
            enc_count = enc_count - 1;
         enc_phase = cur;
      end else if (it.now_ms >= due_ms) begin
         due_ms = it.now_ms + DATA_W'(period);
         r.position = enc_count;
         r.speed = (enc_count - reported_count) * DATA_W'(scale);
         reported_count = enc_count;
         expected_reports.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_item(drive_item);
            items_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_item = pending_items.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.command   <= drive_item.command;
               req_bus.port_bits <= drive_item.port_bits;
               req_bus.now_ms    <= drive_item.now_ms;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected report: position %0d speed %0d",
                   rsp_bus.position, rsp_bus.speed);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_bus.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_bus.position);
               mismatches++;
            end
            if (rsp_bus.speed !== want.speed) begin
               $error("speed: expected %0d, got %0d", want.speed, rsp_bus.speed);
               mismatches++;
            end
            reports_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycles, expected_reports.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] pick_bits(logic [DATA_W-1:0] prefer,
                                                   logic [DATA_W-1:0] fallback);
      logic [DATA_W-1:0] m;
      logic [DATA_W-1:0] r;
      m = (prefer != 0) ? prefer : fallback;
      r = $urandom & m;
      if (r == 0)
         r = m & (~m + 1);
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] make_port(logic a, logic b);
      logic [DATA_W-1:0] p;
      p = $urandom & ~(a_mask | b_mask);
      if (a)
         p |= pick_bits(a_mask & ~b_mask, a_mask);
      if (b)
         p |= pick_bits(b_mask & ~a_mask, b_mask);
      return p;
   endfunction

   function automatic logic [1:0] gray_step(logic [1:0] ab, logic up);
      case (ab)
         2'b00: return up ? 2'b10 : 2'b01;
         2'b10: return up ? 2'b11 : 2'b00;
         2'b11: return up ? 2'b01 : 2'b10;
         default: return up ? 2'b00 : 2'b11;
      endcase
   endfunction

   task automatic queue_port(logic [DATA_W-1:0] p);
      qps_item_type it;
      it.command   = CMD_SAMPLE;
      it.port_bits = p;
      it.now_ms    = $urandom;
      gen_ab = {|(p & a_mask), |(p & b_mask)};
      pending_items.push_back(it);
   endtask

   task automatic queue_sample(logic a, logic b);
      queue_port(make_port(a, b));
   endtask

   task automatic queue_time(logic [DATA_W-1:0] t);
      qps_item_type it;
      it.command   = CMD_TIME;
      it.port_bits = $urandom;
      it.now_ms    = t;
      if (t >= gen_due)
         gen_due = t + DATA_W'(period);
      gen_now = t;
      pending_items.push_back(it);
   endtask

   task automatic queue_random(int n);
      int r;
      logic [DATA_W-1:0] t;
      logic [1:0] nxt;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 20) begin
            if ($urandom_range(99) < 3)
               t = $urandom;
            else
               t = gen_now + $urandom_range(0, 2 * period + 2);
            // jump to the due time when the clock fell far behind it
            if (t < gen_due && gen_due - t > 3 * period + 3)
               t = gen_due;
            queue_time(t);
         end else if (r < 85) begin
            if ($urandom_range(9) == 0)
               walk_up = !walk_up;
            nxt = gray_step(gen_ab, walk_up);
            queue_sample(nxt[1], nxt[0]);
         end else if (r < 95) begin
            queue_sample($urandom_range(1), $urandom_range(1));
         end else begin
            queue_port($urandom);
         end
      end
   endtask

   task automatic write_csr(csr_idx_type idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_PHASE_A_MASK: a_mask = value;
         REG_PHASE_B_MASK: b_mask = value;
         REG_PERIOD_MS:    period = value[PERIOD_W-1:0];
         default:          scale  = value[PERIOD_W-1:0];
      endcase
   endtask

   task automatic set_config(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                             logic [DATA_W-1:0] p, logic [DATA_W-1:0] s);
      write_csr(REG_PHASE_A_MASK, a);
      write_csr(REG_PHASE_B_MASK, b);
      write_csr(REG_PERIOD_MS, p);
      write_csr(REG_SPEED_SCALE, s);
      settings_used++;
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_bus.valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_SAMPLE;
      req_bus.port_bits = '0;
      req_bus.now_ms    = '0;
      rsp_bus.ready     = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first update is always due; then one that is early
      queue_time(32'd0);
      queue_time(32'd5);
      // one full turn up, then five steps down
      queue_sample(1, 0);
      queue_sample(1, 1);
      queue_sample(0, 1);
      queue_sample(0, 0);
      queue_sample(0, 1);
      queue_sample(1, 1);
      queue_sample(1, 0);
      queue_sample(0, 0);
      queue_sample(0, 1);
      // double steps and repeats leave the count alone; one sample among them steps down
      queue_sample(1, 0);
      queue_sample(0, 1);
      queue_sample(0, 1);
      queue_sample(1, 1);
      queue_sample(0, 0);
      queue_port(32'hFFFF_FFFF);
      queue_port(32'h0000_0000);
      // due exactly at the deadline, then a due time that wraps
      queue_time(32'd10);
      queue_time(32'hFFFF_FFFF);
      queue_time(32'd8);
      queue_time(32'd9);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         case (ph)
            1: set_config(32'h8000_0000, 32'h0000_0001, 32'd1, 32'd65535);
            2: set_config(32'hFFFF_0000, 32'h0000_FFFF, 32'd65535, 32'd1);
            3: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
            4: set_config($urandom, $urandom, $urandom_range(1, 200), $urandom_range(0, 65535));
            5: set_config(32'h0000_0F00, 32'h00F0_0000, 32'd7, 32'd3);
            6: set_config(32'hAAAA_AAAA, 32'h5555_5555, 32'd100, 32'd1000);
            7: set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'd3, 32'd2);
            default: ;
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         queue_random(ITEMS_PER_PHASE);
      end
      drain();

      $display("Run covered %0d items and %0d reports under %0d register settings,",
               items_taken, reports_seen, settings_used);
      $display("with idle and stall mixes on both channels.");
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
